### rtl/core/rdz_pkg.sv
// rdz_pkg: shared types and constants for the stick radial dead zone block.
// Depends on nothing; every rtl/core file imports it.
package rdz_pkg;

	localparam int SAMPLE_BITS   = 12;
	localparam int ZONE_BITS     = 15;
	localparam int OUT_BITS      = 16;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 15;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_X_LOW  = 3'd0,
		REG_X_MID  = 3'd1,
		REG_X_HIGH = 3'd2,
		REG_Y_LOW  = 3'd3,
		REG_Y_MID  = 3'd4,
		REG_Y_HIGH = 3'd5,
		REG_INNER  = 3'd6,
		REG_OUTER  = 3'd7
	} cfg_reg_t;

	localparam logic [SAMPLE_BITS-1:0] X_LOW_RST  = 12'd0;
	localparam logic [SAMPLE_BITS-1:0] X_MID_RST  = 12'd2048;
	localparam logic [SAMPLE_BITS-1:0] X_HIGH_RST = 12'd4095;
	localparam logic [SAMPLE_BITS-1:0] Y_LOW_RST  = 12'd0;
	localparam logic [SAMPLE_BITS-1:0] Y_MID_RST  = 12'd2048;
	localparam logic [SAMPLE_BITS-1:0] Y_HIGH_RST = 12'd4095;
	localparam logic [ZONE_BITS-1:0]   INNER_RST  = 15'd4915;
	localparam logic [ZONE_BITS-1:0]   OUTER_RST  = 15'd3277;

	localparam logic [OUT_BITS-1:0] Q15_POS_MAX = 16'h7FFF;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] raw_x;
		logic [SAMPLE_BITS-1:0] raw_y;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] out_x;
		logic signed [OUT_BITS-1:0] out_y;
	} out_item_t;

endpackage

### rtl/core/rdz_axis.sv
// rdz_axis: two-stage axis front end (clamp, then offset and span magnitudes).
// Uses rdz_pkg; feeds a rdz_div_pipe in the top level.
module rdz_axis
	import rdz_pkg::*;
(
	input  logic                   clk,
	input  logic                   adv,
	input  logic [SAMPLE_BITS-1:0] raw,
	input  logic [SAMPLE_BITS-1:0] lo,
	input  logic [SAMPLE_BITS-1:0] mid,
	input  logic [SAMPLE_BITS-1:0] hi,
	output logic [SAMPLE_BITS-1:0] dabs_s2,
	output logic [SAMPLE_BITS-1:0] sabs_s2,
	output logic                   neg_s2,
	output logic                   zero_s2
);

	logic [SAMPLE_BITS-1:0] v_s1;
	logic [SAMPLE_BITS-1:0] v_c;
	logic [SAMPLE_BITS:0]   d_c;
	logic [SAMPLE_BITS:0]   span_c;
	logic [SAMPLE_BITS:0]   dneg_c;
	logic [SAMPLE_BITS:0]   sneg_c;

	// clamp: below minimum wins over above maximum
	always_comb begin
		if (raw < lo) begin
			v_c = lo;
		end else if (raw > hi) begin
			v_c = hi;
		end else begin
			v_c = raw;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1 <= v_c;
		end
	end

	always_comb begin
		d_c = {1'b0, v_s1} - {1'b0, mid};
		if (v_s1 >= mid) begin
			span_c = {1'b0, hi} - {1'b0, mid};
		end else begin
			span_c = {1'b0, mid} - {1'b0, lo};
		end
		dneg_c = -d_c;
		sneg_c = -span_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dabs_s2 <= d_c[SAMPLE_BITS] ? dneg_c[SAMPLE_BITS-1:0] : d_c[SAMPLE_BITS-1:0];
			sabs_s2 <= span_c[SAMPLE_BITS] ? sneg_c[SAMPLE_BITS-1:0]
				: span_c[SAMPLE_BITS-1:0];
			neg_s2  <= d_c[SAMPLE_BITS] ^ span_c[SAMPLE_BITS];
			zero_s2 <= (span_c == '0);
		end
	end

endmodule

### rtl/core/rdz_div_pipe.sv
// rdz_div_pipe: restoring unsigned divider, one quotient bit per stage.
// Uses rdz_pkg; instantiated by the top level for all three divisions.
module rdz_div_pipe
	import rdz_pkg::*;
#(
	parameter int DW = 12,
	parameter int QB = 16,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          in_valid,
	input  logic [DW-1:0] in_rem,   // high part of numerator, below in_den
	input  logic [QB-1:0] in_bits,  // remaining numerator bits, MSB first
	input  logic [DW-1:0] in_den,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [QB-1:0] out_q,
	output logic [SW-1:0] out_side
);

	logic          v_s    [0:QB];
	logic [DW-1:0] rem_s  [0:QB];
	logic [QB-1:0] bits_s [0:QB];
	logic [QB-1:0] q_s    [0:QB];
	logic [DW-1:0] den_s  [0:QB];
	logic [SW-1:0] side_s [0:QB];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = in_rem;
	assign bits_s[0] = in_bits;
	assign q_s[0]    = '0;
	assign den_s[0]  = in_den;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [DW:0] t_c;
		logic [DW:0] diff_c;
		logic        ge_c;

		always_comb begin
			t_c    = {rem_s[k], bits_s[k][QB-1]};
			diff_c = t_c - {1'b0, den_s[k]};
			ge_c   = (t_c >= {1'b0, den_s[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1]  <= ge_c ? diff_c[DW-1:0] : t_c[DW-1:0];
				bits_s[k+1] <= bits_s[k] << 1;
				q_s[k+1]    <= {q_s[k][QB-2:0], ge_c};
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[QB];
	assign out_q     = q_s[QB];
	assign out_side  = side_s[QB];

endmodule

### rtl/core/rdz_sqrt_pipe.sv
// rdz_sqrt_pipe: digit-by-digit integer square root, one root bit per stage.
// Uses rdz_pkg; instantiated by the top level for the vector magnitude.
module rdz_sqrt_pipe
	import rdz_pkg::*;
#(
	parameter int K  = 16,
	parameter int SW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_valid,
	input  logic [2*K-1:0] in_rad,
	input  logic [SW-1:0]  in_side,
	output logic           out_valid,
	output logic [K-1:0]   out_root,
	output logic [SW-1:0]  out_side
);

	localparam int RMW = K + 2;

	logic           v_s    [0:K];
	logic [RMW-1:0] rem_s  [0:K];
	logic [K-1:0]   root_s [0:K];
	logic [2*K-1:0] rad_s  [0:K];
	logic [SW-1:0]  side_s [0:K];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = in_rad;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < K; k++) begin : g_stage
		logic [RMW+1:0] t_c;
		logic [RMW+1:0] trial_c;
		logic [RMW+1:0] diff_c;
		logic           ge_c;

		always_comb begin
			t_c     = {rem_s[k], rad_s[k][2*K-1 -: 2]};
			trial_c = {2'b00, root_s[k], 2'b01};
			diff_c  = t_c - trial_c;
			ge_c    = (t_c >= trial_c);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1]  <= ge_c ? diff_c[RMW-1:0] : t_c[RMW-1:0];
				root_s[k+1] <= {root_s[k][K-2:0], ge_c};
				rad_s[k+1]  <= rad_s[k] << 2;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[K];
	assign out_root  = root_s[K];
	assign out_side  = side_s[K];

endmodule

### rtl/core/stick_radial_deadzone_top.sv
// stick_radial_deadzone_top: scaled radial dead zone for one analog stick.
// Uses rdz_pkg, rdz_axis, rdz_div_pipe and rdz_sqrt_pipe.
//
// Usage:
//  - Input channel in_valid/in_stall/in_item carries one raw (x, y) sample.
//    An item is taken on a clock edge with in_valid high and in_stall low.
//  - Output channel out_valid/out_stall/out_item carries the conditioned
//    Q1.15 pair; out_item holds steady while out_valid and out_stall are high.
//  - cfg_we/cfg_index/cfg_data write the calibration and zone registers;
//    write them only while no item is in flight.
//  - Throughput: one item per clock while the output is not held. The pipe
//    has two front-end stages, three restoring dividers and one square root
//    of FRAC_BITS+1 stages each (one bit per stage), plus the axis magnitude,
//    square, sum, zone, norm, product and output stages.
//  - The whole pipe moves in lock step. It holds only while the output
//    register is full and stalled; in_stall then follows out_stall, so
//    nothing is dropped or repeated.
//  - Reset clears every valid bit and loads the register defaults
//    (centre 2048, range 0..4095, inner 0.15, outer 0.10).
module stick_radial_deadzone_top
	import rdz_pkg::*;
#(
	parameter int FRAC_BITS = 15
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  in_item_t                 in_item,
	output logic                     out_valid,
	input  logic                     out_stall,
	output out_item_t                out_item,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int F  = FRAC_BITS;
	localparam int K  = F + 1;                // magnitude bits, holds 1.0
	localparam logic [K-1:0] ONE_Q = K'(1) << F;
	localparam int SW2 = 3 + K + 2 * (K + 1);

	// configuration registers
	logic [SAMPLE_BITS-1:0] x_low_q, x_mid_q, x_high_q;
	logic [SAMPLE_BITS-1:0] y_low_q, y_mid_q, y_high_q;
	logic [ZONE_BITS-1:0]   inner_q, outer_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q  <= X_LOW_RST;
			x_mid_q  <= X_MID_RST;
			x_high_q <= X_HIGH_RST;
			y_low_q  <= Y_LOW_RST;
			y_mid_q  <= Y_MID_RST;
			y_high_q <= Y_HIGH_RST;
			inner_q  <= INNER_RST;
			outer_q  <= OUTER_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_X_LOW:  x_low_q  <= cfg_data[SAMPLE_BITS-1:0];
				REG_X_MID:  x_mid_q  <= cfg_data[SAMPLE_BITS-1:0];
				REG_X_HIGH: x_high_q <= cfg_data[SAMPLE_BITS-1:0];
				REG_Y_LOW:  y_low_q  <= cfg_data[SAMPLE_BITS-1:0];
				REG_Y_MID:  y_mid_q  <= cfg_data[SAMPLE_BITS-1:0];
				REG_Y_HIGH: y_high_q <= cfg_data[SAMPLE_BITS-1:0];
				REG_INNER:  inner_q  <= cfg_data[ZONE_BITS-1:0];
				REG_OUTER:  outer_q  <= cfg_data[ZONE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// zones rescaled from Q0.15 to F fraction bits; band = 1.0 - inner - outer
	logic [ZONE_BITS+F-1:0] inner_w, outer_w;
	logic [K-1:0]           inner_c, outer_c;
	logic [K:0]             band_c;
	logic                   band_pos_c;

	always_comb begin
		inner_w    = {inner_q, {F{1'b0}}} >> ZONE_BITS;
		outer_w    = {outer_q, {F{1'b0}}} >> ZONE_BITS;
		inner_c    = {1'b0, inner_w[F-1:0]};
		outer_c    = {1'b0, outer_w[F-1:0]};
		band_c     = {1'b0, ONE_Q} - {1'b0, inner_c} - {1'b0, outer_c};
		band_pos_c = !band_c[K] && (band_c != '0);
	end

	// whole pipe advances unless the output register is held
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// front end: clamp, offset and span
	logic v_s1, v_s2;
	logic [SAMPLE_BITS-1:0] dx_s2, sx_span_s2, dy_s2, sy_span_s2;
	logic nx_s2, zx_s2, ny_s2, zy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	rdz_axis u_axis_x (
		.clk(clk), .adv(adv), .raw(in_item.raw_x),
		.lo(x_low_q), .mid(x_mid_q), .hi(x_high_q),
		.dabs_s2(dx_s2), .sabs_s2(sx_span_s2), .neg_s2(nx_s2), .zero_s2(zx_s2)
	);

	rdz_axis u_axis_y (
		.clk(clk), .adv(adv), .raw(in_item.raw_y),
		.lo(y_low_q), .mid(y_mid_q), .hi(y_high_q),
		.dabs_s2(dy_s2), .sabs_s2(sy_span_s2), .neg_s2(ny_s2), .zero_s2(zy_s2)
	);

	// axis division: |d| * 2^F / |span|, saturating at 1.0
	logic [SAMPLE_BITS-1:0] rx_init, ry_init;
	logic                   ovx_c, ovy_c;
	logic                   d1x_v, d1y_v;
	logic [K-1:0]           q1x, q1y;
	logic [2:0]             s1x, s1y;

	always_comb begin
		rx_init = {1'b0, dx_s2[SAMPLE_BITS-1:1]};
		ry_init = {1'b0, dy_s2[SAMPLE_BITS-1:1]};
		ovx_c   = (rx_init >= sx_span_s2);
		ovy_c   = (ry_init >= sy_span_s2);
	end

	rdz_div_pipe #(.DW(SAMPLE_BITS), .QB(K), .SW(3)) u_div_ax (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(v_s2),
		.in_rem(rx_init), .in_bits({dx_s2[0], {F{1'b0}}}), .in_den(sx_span_s2),
		.in_side({nx_s2, zx_s2, ovx_c}),
		.out_valid(d1x_v), .out_q(q1x), .out_side(s1x)
	);

	// Y is inverted: its sign flag is flipped here
	rdz_div_pipe #(.DW(SAMPLE_BITS), .QB(K), .SW(3)) u_div_ay (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(v_s2),
		.in_rem(ry_init), .in_bits({dy_s2[0], {F{1'b0}}}), .in_den(sy_span_s2),
		.in_side({!ny_s2, zy_s2, ovy_c}),
		.out_valid(d1y_v), .out_q(q1y), .out_side(s1y)
	);

	// axis magnitude and sign
	logic v_s3, v_s4, v_s5;
	logic [K-1:0] amx_s3, amy_s3, amx_s4, amy_s4, amx_s5, amy_s5;
	logic sx_s3, sy_s3, sx_s4, sy_s4, sx_s5, sy_s5;
	logic [2*K-1:0] sqx_s4, sqy_s4, sum_s5;

	function automatic logic [K-1:0] axis_mag(input logic [K-1:0] q,
		input logic zero, input logic ovf);
		logic [K-1:0] r;
		if (zero) begin
			r = '0;
		end else if (ovf || q > ONE_Q) begin
			r = ONE_Q;
		end else begin
			r = q;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s3 <= d1x_v && d1y_v;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			amx_s3 <= axis_mag(q1x, s1x[1], s1x[0]);
			amy_s3 <= axis_mag(q1y, s1y[1], s1y[0]);
			sx_s3  <= s1x[2];
			sy_s3  <= s1y[2];
			sqx_s4 <= amx_s3 * amx_s3;
			sqy_s4 <= amy_s3 * amy_s3;
			amx_s4 <= amx_s3;
			amy_s4 <= amy_s3;
			sx_s4  <= sx_s3;
			sy_s4  <= sy_s3;
			sum_s5 <= sqx_s4 + sqy_s4;
			amx_s5 <= amx_s4;
			amy_s5 <= amy_s4;
			sx_s5  <= sx_s4;
			sy_s5  <= sy_s4;
		end
	end

	// vector magnitude
	logic             sq_v;
	logic [K-1:0]     root_c;
	logic [2*K+1:0]   sq_side;

	rdz_sqrt_pipe #(.K(K), .SW(2*K+2)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(v_s5),
		.in_rad(sum_s5), .in_side({amx_s5, sx_s5, amy_s5, sy_s5}),
		.out_valid(sq_v), .out_root(root_c), .out_side(sq_side)
	);

	// dead zone test and band numerator
	logic           v_s6;
	logic [K-1:0]   root_s6, num_s6;
	logic           le_s6;
	logic [2*K+1:0] ax_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			root_s6 <= root_c;
			num_s6  <= root_c - inner_c;
			le_s6   <= (root_c <= inner_c);
			ax_s6   <= sq_side;
		end
	end

	// rescale over the band: (mag - inner) * 2^F / band
	logic [K-1:0]   r2_init;
	logic           ov2_c;
	logic           d2_v;
	logic [K-1:0]   q2;
	logic [SW2-1:0] s2;

	always_comb begin
		r2_init = {1'b0, num_s6[K-1:1]};
		ov2_c   = (r2_init >= band_c[K-1:0]);
	end

	rdz_div_pipe #(.DW(K), .QB(K), .SW(SW2)) u_div_band (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(v_s6),
		.in_rem(r2_init), .in_bits({num_s6[0], {F{1'b0}}}), .in_den(band_c[K-1:0]),
		.in_side({le_s6, ov2_c, band_pos_c, root_s6, ax_s6}),
		.out_valid(d2_v), .out_q(q2), .out_side(s2)
	);

	// side layout: le, ovf, band_pos, root, amx, sx, amy, sy
	logic         le_c2, ov_c2, bpos_c2, sx_c2, sy_c2;
	logic [K-1:0] root_c2, amx_c2, amy_c2;

	assign {le_c2, ov_c2, bpos_c2, root_c2, amx_c2, sx_c2, amy_c2, sy_c2} = s2;

	logic         v_s7, v_s8;
	logic [K-1:0] norm_s7, root_s7, amx_s7, amy_s7, root_s8;
	logic         le_s7, sx_s7, sy_s7, le_s8, sx_s8, sy_s8;
	logic [2*K-1:0] px_s8, py_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s7 <= d2_v;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// empty band or quotient past 1.0 gives full scale
			norm_s7 <= (!bpos_c2 || ov_c2 || q2 > ONE_Q) ? ONE_Q : q2;
			root_s7 <= root_c2;
			amx_s7  <= amx_c2;
			amy_s7  <= amy_c2;
			le_s7   <= le_c2;
			sx_s7   <= sx_c2;
			sy_s7   <= sy_c2;
			px_s8   <= amx_s7 * norm_s7;
			py_s8   <= amy_s7 * norm_s7;
			root_s8 <= root_s7;
			le_s8   <= le_s7;
			sx_s8   <= sx_s7;
			sy_s8   <= sy_s7;
		end
	end

	// apply: |axis| * norm / mag; |axis| <= mag keeps the quotient within K bits
	logic         d3x_v, d3y_v;
	logic [K-1:0] q3x, q3y;
	logic [1:0]   s3x;
	logic         s3y;

	rdz_div_pipe #(.DW(K), .QB(K), .SW(2)) u_div_ox (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(v_s8),
		.in_rem(px_s8[2*K-1:K]), .in_bits(px_s8[K-1:0]), .in_den(root_s8),
		.in_side({le_s8, sx_s8}),
		.out_valid(d3x_v), .out_q(q3x), .out_side(s3x)
	);

	rdz_div_pipe #(.DW(K), .QB(K), .SW(1)) u_div_oy (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(v_s8),
		.in_rem(py_s8[2*K-1:K]), .in_bits(py_s8[K-1:0]), .in_den(root_s8),
		.in_side(sy_s8),
		.out_valid(d3y_v), .out_q(q3y), .out_side(s3y)
	);

	// Q1.15 conversion, truncating toward zero, saturating the positive end
	function automatic logic [OUT_BITS-1:0] to_q15(input logic [K-1:0] m,
		input logic neg, input logic zero);
		logic [K+ZONE_BITS-1:0] w;
		logic [OUT_BITS-1:0]    u;
		logic [OUT_BITS-1:0]    r;
		w = {m, {ZONE_BITS{1'b0}}} >> F;
		u = w[OUT_BITS-1:0];
		if (zero) begin
			r = '0;
		end else if (neg) begin
			r = -u;
		end else if (u[OUT_BITS-1]) begin
			r = Q15_POS_MAX;
		end else begin
			r = u;
		end
		return r;
	endfunction

	logic      out_valid_q;
	out_item_t out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= d3x_v && d3y_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_item_q.out_x <= to_q15(q3x, s3x[0], s3x[1]);
			out_item_q.out_y <= to_q15(q3y, s3y, s3x[1]);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// checks
	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (amx_s3 <= ONE_Q) && (amy_s3 <= ONE_Q))
		else $error("axis magnitude above full scale");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> norm_s7 <= ONE_Q)
		else $error("rescaled magnitude above full scale");

	a_apply_range: assert property (@(posedge clk) disable iff (!arst_n)
		(d3x_v && !s3x[1]) |-> (q3x <= ONE_Q) && (q3y <= ONE_Q))
		else $error("applied axis exceeds full scale");

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(d1x_v == d1y_v) && (d3x_v == d3y_v))
		else $error("x and y lanes out of step");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input held without a waiting output item");

endmodule

### tb/sv/stick_radial_deadzone_top_test.sv
// Testbench for stick_radial_deadzone_top, depends on rdz_pkg and the RTL:
// directed table and random samples, checked by a local predictor or typed pairs.
`timescale 1ns / 100ps

module stick_radial_deadzone_top_test;
	import rdz_pkg::*;

	localparam int  ONE_Q       = 32768;
	localparam int  STALL_LIMIT = 20000;   // cycles with no handshake at all
	localparam int  DRAIN_WAIT  = 100;     // pipe is 73 deep
	localparam int  HOLD_CYCLES = 300;     // long receiver hold-off, fills the pipe
	localparam int  RAND_PHASES = 6;
	localparam int  RAND_ITEMS  = 220;
	localparam int  SPECIAL_ITEMS = 12;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	in_item_t                 in_item = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	out_item_t                out_item;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	stick_radial_deadzone_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow copy of the register file, indexed by cfg_reg_t
	int unsigned cal_regs [8];
	out_item_t   pending_outs [$];
	int          mismatches = 0;
	int          items_sent = 0;
	int          outs_seen = 0;
	bit          calm = 1'b0;      // no random idling on either side
	bit          done = 1'b0;

	typedef struct {
		logic [SAMPLE_BITS-1:0] rx;
		logic [SAMPLE_BITS-1:0] ry;
		bit                     typed;   // expected pair given inline
		logic signed [15:0]     ex;
		logic signed [15:0]     ey;
	} row_t;

	// Directed rows under reset calibration: centre, the four extremes and
	// corners, values near the dead zone edge.
	row_t dir_rows [] = '{
		'{12'd2048, 12'd2048, 1, 16'sd0,     16'sd0},
		'{12'd4095, 12'd2048, 1, 16'sd32767, 16'sd0},
		'{12'd0,    12'd2048, 1, -16'sd32768, 16'sd0},
		'{12'd2048, 12'd0,    1, 16'sd0,     16'sd32767},
		'{12'd2048, 12'd4095, 1, 16'sd0,     -16'sd32768},
		'{12'd0,    12'd0,    0, 0, 0},
		'{12'd4095, 12'd4095, 0, 0, 0},
		'{12'd0,    12'd4095, 0, 0, 0},
		'{12'd4095, 12'd0,    0, 0, 0},
		'{12'd2355, 12'd2048, 0, 0, 0},
		'{12'd2356, 12'd2048, 0, 0, 0},
		'{12'd2400, 12'd1700, 0, 0, 0},
		'{12'd3800, 12'd2048, 0, 0, 0},
		'{12'd2049, 12'd2047, 0, 0, 0},
		'{12'd4095, 12'd1,    0, 0, 0}
	};

	// Special calibrations: x_low, x_mid, x_high, y_low, y_mid, y_high, inner, outer
	int unsigned special_cfg [][8] = '{
		'{2048, 2048, 2048, 100, 100, 4000, 4915, 3277},   // zero span on x, y below
		'{3000, 2000, 1000, 3500, 2048, 500, 4915, 3277},  // minimum above maximum
		'{100, 4000, 3000, 1000, 10, 3000, 1000, 1000},    // centre outside range
		'{0, 2048, 4095, 0, 2048, 4095, 20000, 20000},     // band negative
		'{0, 2048, 4095, 0, 2048, 4095, 16384, 16384},     // band exactly empty
		'{0, 2048, 4095, 0, 2048, 4095, 0, 0},
		'{0, 2048, 4095, 0, 2048, 4095, 32767, 0},
		'{0, 0, 0, 0, 0, 0, 0, 32767},
		'{4095, 4095, 4095, 4095, 4095, 4095, 0, 0}
	};

	// ---------------- predictor ----------------
	function automatic longint axis_q(int unsigned raw, int unsigned lo,
			int unsigned mid, int unsigned hi);
		longint v, d, span, q;
		v = raw;
		if (v < lo)
			v = lo;
		else if (v > hi)
			v = hi;
		d = v - longint'(mid);
		span = (v >= mid) ? longint'(hi) - longint'(mid) : longint'(mid) - longint'(lo);
		if (span == 0)
			return 0;
		q = (d * ONE_Q) / span;    // truncates toward zero
		if (q > ONE_Q) q = ONE_Q;
		if (q < -ONE_Q) q = -ONE_Q;
		return q;
	endfunction

	function automatic longint root_floor(longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(root);
	endfunction

	function automatic logic signed [15:0] sat_q15(longint v);
		longint r;
		r = (v * 32768) / ONE_Q;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	function automatic out_item_t shape_sample(in_item_t s);
		longint ax, ay, inner, outer, mag, band, norm;
		out_item_t o;
		ax = axis_q(s.raw_x, cal_regs[REG_X_LOW], cal_regs[REG_X_MID], cal_regs[REG_X_HIGH]);
		ay = -axis_q(s.raw_y, cal_regs[REG_Y_LOW], cal_regs[REG_Y_MID], cal_regs[REG_Y_HIGH]);
		inner = (longint'(cal_regs[REG_INNER]) * ONE_Q) >> 15;
		outer = (longint'(cal_regs[REG_OUTER]) * ONE_Q) >> 15;
		mag = root_floor(ax * ax + ay * ay);
		o = '0;
		if (mag <= inner)
			return o;
		band = ONE_Q - inner - outer;
		if (band <= 0) begin
			norm = ONE_Q;
		end else begin
			norm = ((mag - inner) * ONE_Q) / band;
			if (norm > ONE_Q) norm = ONE_Q;
		end
		o.out_x = sat_q15((ax * norm) / mag);
		o.out_y = sat_q15((ay * norm) / mag);
		return o;
	endfunction

	// ---------------- checking ----------------
	task automatic report_mismatch(string what, out_item_t got, out_item_t want);
		mismatches++;
		$display("MISMATCH %s at %0t: got (%0d,%0d) want (%0d,%0d)", what, $realtime,
			got.out_x, got.out_y, want.out_x, want.out_y);
	endtask

	// receiver: random stall, one long hold-off once 600 results have been seen
	initial begin : receiver
		out_item_t want;
		bit        held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && outs_seen >= 600) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= (!calm && $urandom_range(99) < 33);
			@(posedge clk);
			if (out_valid && !out_stall) begin
				outs_seen++;
				if (pending_outs.size() == 0) begin
					report_mismatch("unexpected item", out_item, '0);
				end else begin
					want = pending_outs.pop_front();
					if (out_item.out_x !== want.out_x || out_item.out_y !== want.out_y)
						report_mismatch("field", out_item, want);
				end
			end
		end
	end

	// watchdog: cycles with no handshake on either channel and no config write
	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles", quiet);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// ---------------- stimulus ----------------
	task automatic send_sample(in_item_t s);
		// each idle cycle drawn on its own, about a third of all cycles
		while (!calm && $urandom_range(99) < 33) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= s;
		do @(posedge clk); while (in_stall);
		pending_outs.push_back(shape_sample(s));
		items_sent++;
		// calm stretch early in the random phases (items 300 to 499)
		calm = (items_sent >= 300 && items_sent < 500);
	endtask

	// only called with the pipe drained; every item yields a result
	task automatic load_cal(int unsigned vals [8]);
		in_valid <= 1'b0;
		wait (pending_outs.size() == 0);
		@(posedge clk);
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= i[CFG_IDX_BITS-1:0];
			cfg_data  <= vals[i][CFG_DATA_BITS-1:0];
			@(posedge clk);
			cal_regs[i] = (i < REG_INNER) ? (vals[i] & 12'hFFF) : (vals[i] & 15'h7FFF);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic in_item_t rand_sample();
		in_item_t s;
		if ($urandom_range(3) == 0) begin
			// near the centre, where the dead zone edge sits
			s.raw_x = 12'($urandom_range(1500, 2600));
			s.raw_y = 12'($urandom_range(1500, 2600));
		end else begin
			s.raw_x = 12'($urandom);
			s.raw_y = 12'($urandom);
		end
		return s;
	endfunction

	initial begin : sender
		in_item_t    s;
		out_item_t   want;
		int unsigned vals [8];
		cal_regs = '{X_LOW_RST, X_MID_RST, X_HIGH_RST, Y_LOW_RST, Y_MID_RST, Y_HIGH_RST,
			INNER_RST, OUTER_RST};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under reset calibration
		foreach (dir_rows[i]) begin
			s.raw_x = dir_rows[i].rx;
			s.raw_y = dir_rows[i].ry;
			send_sample(s);
			if (dir_rows[i].typed) begin
				// typed-in value replaces the predicted one
				want.out_x = dir_rows[i].ex;
				want.out_y = dir_rows[i].ey;
				pending_outs[pending_outs.size()-1] = want;
			end
		end

		// special calibrations, each with the extremes, the centre and random samples
		foreach (special_cfg[p]) begin
			vals = special_cfg[p];
			load_cal(vals);
			for (int k = 0; k < SPECIAL_ITEMS; k++) begin
				case (k)
					0: s = '{12'd0, 12'd0};
					1: s = '{12'hFFF, 12'hFFF};
					2: s = '{12'(vals[REG_X_MID]), 12'(vals[REG_Y_MID])};
					default: s = rand_sample();
				endcase
				send_sample(s);
			end
		end

		// random calibrations, mostly well-formed low < mid < high
		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p == 0) begin
				vals = '{X_LOW_RST, X_MID_RST, X_HIGH_RST, Y_LOW_RST, Y_MID_RST,
					Y_HIGH_RST, INNER_RST, OUTER_RST};
			end else if (p % 3 == 2) begin
				foreach (vals[i]) vals[i] = (i < REG_INNER) ? $urandom_range(4095)
					: $urandom_range(32767);
			end else begin
				vals[REG_X_LOW]  = $urandom_range(0, 800);
				vals[REG_X_MID]  = $urandom_range(1500, 2600);
				vals[REG_X_HIGH] = $urandom_range(3300, 4095);
				vals[REG_Y_LOW]  = $urandom_range(0, 800);
				vals[REG_Y_MID]  = $urandom_range(1500, 2600);
				vals[REG_Y_HIGH] = $urandom_range(3300, 4095);
				vals[REG_INNER]  = $urandom_range(0, 12000);
				vals[REG_OUTER]  = $urandom_range(0, 12000);
			end
			load_cal(vals);
			repeat (RAND_ITEMS) send_sample(rand_sample());
		end
		in_valid <= 1'b0;

		wait (pending_outs.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("Covered %0d samples over %0d calibrations, %0d results checked.",
			items_sent, 1 + special_cfg.size() + RAND_PHASES, outs_seen);
		$display("Included zero span, inverted range, off-range centre and empty band.");
		if (mismatches == 0 && pending_outs.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
